[rtl/core/dh_forward_kinematics_3joint_core_macros.svh]
// Assertion macros shared by the checkers of the kinematics core.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef DH_FORWARD_KINEMATICS_3JOINT_CORE_MACROS_SVH
`define DH_FORWARD_KINEMATICS_3JOINT_CORE_MACROS_SVH
// Checked on every rising edge outside reset.
`define DHFK_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define DHFK_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

[rtl/core/dhfk_pkg.sv]
// Shared types, constants and rounding helpers of the kinematics core.
// No dependencies.
package dhfk_pkg;

  localparam int JOINTS = 3;
  localparam int JOINTS_USED = (JOINTS > 3) ? 3 : JOINTS;
  localparam int CELL_LAT = 17;

  localparam int FULL_TURN = 46080;
  localparam int QUARTER_TURN = 11520;
  localparam int EIGHTH_TURN = 5760;
  localparam int RAD_PER_UNIT_Q30 = 146409;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  localparam logic [2:0] CFG_LINK_LENGTH_0 = 3'd0;
  localparam logic [2:0] CFG_LINK_LENGTH_1 = 3'd1;
  localparam logic [2:0] CFG_LINK_LENGTH_2 = 3'd2;
  localparam logic [2:0] CFG_LINK_OFFSET_0 = 3'd3;
  localparam logic [2:0] CFG_LINK_OFFSET_1 = 3'd4;
  localparam logic [2:0] CFG_LINK_OFFSET_2 = 3'd5;
  localparam logic [2:0] CFG_TWIST_CODES = 3'd6;

  typedef enum logic [1:0] {
    TWIST_0   = 2'd0,
    TWIST_90  = 2'd1,
    TWIST_180 = 2'd2,
    TWIST_270 = 2'd3
  } twist_t;

  typedef logic [2:0][2:0][15:0] rot_t;
  typedef logic [2:0][31:0] pos_t;
  typedef logic [2:0][15:0] ang_t;

  // Transform accumulated so far plus the angles still to be consumed.
  typedef struct packed {
    rot_t rot;
    pos_t pos;
    ang_t ang;
  } hstate_t;

  // Round a Q14-scaled value to an integer, ties away from zero.
  function automatic logic signed [39:0] rnd14(logic signed [39:0] v);
    logic signed [39:0] mag;
    logic signed [39:0] res;
    mag = v[39] ? -v : v;
    res = (mag + 40'sd8192) >>> 14;
    return v[39] ? -res : res;
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [39:0] v);
    if (v > 40'sd32767) return 16'sh7fff;
    if (v < -40'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(logic signed [31:0] v);
    if (v > 32'sd8388607) return 24'sh7fffff;
    if (v < -32'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

[rtl/core/dh_forward_kinematics_3joint_core.sv]
// Three-joint Denavit-Hartenberg forward kinematics core, one cell per joint.
// Items pass through the cells in turn, then the output register. Throughput:
// one item per cycle unless the last stage and the output register are full
// and out_ready is low. Each cell runs its sine/cosine pipeline, then its matrix
// product stages. Reset (synchronous, rst_n low) clears the valid bits and
// out_valid and loads the configuration defaults; result data is not reset.
module dh_forward_kinematics_3joint_core import dhfk_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_angle_0,
  input  logic signed [15:0] in_angle_1,
  input  logic signed [15:0] in_angle_2,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_rot_00,
  output logic signed [15:0] out_rot_01,
  output logic signed [15:0] out_rot_02,
  output logic signed [15:0] out_rot_10,
  output logic signed [15:0] out_rot_11,
  output logic signed [15:0] out_rot_12,
  output logic signed [15:0] out_rot_20,
  output logic signed [15:0] out_rot_21,
  output logic signed [15:0] out_rot_22,
  output logic signed [23:0] out_pos_x,
  output logic signed [23:0] out_pos_y,
  output logic signed [23:0] out_pos_z
);

  localparam int LAT = JOINTS_USED * CELL_LAT;

  // Configuration registers, one link length and offset per joint.
  logic signed [15:0] link_len_r [3];
  logic signed [15:0] link_off_r [3];
  logic [5:0]         twist_r;

  // The pipeline moves as a whole. It keeps moving while the last stage is
  // empty, so items are still taken while a finished result waits in the
  // output register.
  logic            en;
  logic [LAT-1:0]  vld_r;
  logic            out_valid_r;
  logic            load;
  hstate_t         h [0:JOINTS_USED];
  hstate_t         res_r;

  assign en = !vld_r[LAT-1] || !out_valid_r || out_ready;
  assign load = vld_r[LAT-1] && (!out_valid_r || out_ready);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_len_r[0] <= 16'sd0;
      link_len_r[1] <= 16'sd256;
      link_len_r[2] <= 16'sd256;
      link_off_r[0] <= 16'sd256;
      link_off_r[1] <= 16'sd0;
      link_off_r[2] <= 16'sd0;
      twist_r <= 6'd3;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LINK_LENGTH_0: link_len_r[0] <= cfg_wdata;
        CFG_LINK_LENGTH_1: link_len_r[1] <= cfg_wdata;
        CFG_LINK_LENGTH_2: link_len_r[2] <= cfg_wdata;
        CFG_LINK_OFFSET_0: link_off_r[0] <= cfg_wdata;
        CFG_LINK_OFFSET_1: link_off_r[1] <= cfg_wdata;
        CFG_LINK_OFFSET_2: link_off_r[2] <= cfg_wdata;
        CFG_TWIST_CODES:   twist_r <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the data of the cells.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[LAT-2:0], in_valid};
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The chain starts from the identity transform at the origin.
  always_comb begin
    h[0].rot = '0;
    h[0].rot[0][0] = ONE_Q14;
    h[0].rot[1][1] = ONE_Q14;
    h[0].rot[2][2] = ONE_Q14;
    h[0].pos = '0;
    h[0].ang = {in_angle_2, in_angle_1, in_angle_0};
  end

  for (genvar j = 0; j < JOINTS_USED; j++) begin : g_cell
    dhfk_cell u_cell (
      .clk      (clk),
      .en       (en),
      .link_len (link_len_r[j]),
      .link_off (link_off_r[j]),
      .twist    (twist_t'(twist_r[2*j +: 2])),
      .h_in     (h[j]),
      .h_out    (h[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= h[JOINTS_USED];
    end
  end

  assign out_valid  = out_valid_r;
  assign out_rot_00 = res_r.rot[0][0];
  assign out_rot_01 = res_r.rot[0][1];
  assign out_rot_02 = res_r.rot[0][2];
  assign out_rot_10 = res_r.rot[1][0];
  assign out_rot_11 = res_r.rot[1][1];
  assign out_rot_12 = res_r.rot[1][2];
  assign out_rot_20 = res_r.rot[2][0];
  assign out_rot_21 = res_r.rot[2][1];
  assign out_rot_22 = res_r.rot[2][2];
  // Positions are kept at 32 bits through the chain and clipped only here.
  assign out_pos_x  = sat24($signed(res_r.pos[0]));
  assign out_pos_y  = sat24($signed(res_r.pos[1]));
  assign out_pos_z  = sat24($signed(res_r.pos[2]));

endmodule

[rtl/core/dhfk_sincos.sv]
// Pipelined sine and cosine of an angle in 1/128 degree, result Q14.
// Depends on dhfk_pkg. Thirteen register stages, one angle per cycle while en is high.
module dhfk_sincos import dhfk_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] ang,
  output logic signed [15:0] sin_out,
  output logic signed [15:0] cos_out
);

  localparam logic [31:0] RECIP_42 = 32'((64'd1 << 32) / 42);
  localparam logic [31:0] RECIP_20 = 32'((64'd1 << 32) / 20);
  localparam logic [31:0] RECIP_6  = 32'((64'd1 << 32) / 6);
  localparam logic [31:0] RECIP_56 = 32'((64'd1 << 32) / 56);
  localparam logic [31:0] RECIP_30 = 32'((64'd1 << 32) / 30);
  localparam logic [31:0] RECIP_12 = 32'((64'd1 << 32) / 12);

  typedef struct packed {
    logic       swap;
    logic [1:0] quad;
  } sc_ctl_t;

  // Quotient estimate by reciprocal; low by at most one.
  function automatic logic [29:0] recip_est(logic [29:0] n, logic [31:0] m);
    logic [61:0] p;
    p = 62'(n) * 62'(m);
    return p[61:32];
  endfunction

  function automatic logic [29:0] recip_fix(logic [29:0] n, logic [29:0] q0, logic [5:0] d);
    logic [35:0] prod;
    logic [29:0] rem;
    prod = 36'(q0) * 36'(d);
    rem = n - prod[29:0];
    return (rem >= 30'(d)) ? q0 + 30'd1 : q0;
  endfunction

  function automatic logic [29:0] mul_q30(logic [29:0] a, logic [30:0] b);
    logic [60:0] p;
    p = 61'(a) * 61'(b);
    return p[59:30];
  endfunction

  sc_ctl_t     ctl_r [0:11];
  logic [12:0] r_r;
  logic [29:0] x_r  [1:10];
  logic [29:0] x2_r [2:10];
  logic [30:0] sn_r [3:11];
  logic [30:0] cs_r [3:11];
  logic [29:0] ns6_r, nc6_r, ns9_r, nc9_r;

  logic [16:0] t;
  logic [1:0]  quad;
  logic [13:0] rem;
  logic [14:0] sin_b, cos_b;
  logic [30:0] cos_v4;
  logic [31:0] cos_sum;
  logic [30:0] sin_sum;
  logic [59:0] x_sq;
  logic [30:0] x_full;

  always_comb begin
    t = ang[15] ? 17'(ang) + 17'(FULL_TURN) : 17'(ang);
    if (t >= 17'(3 * QUARTER_TURN)) begin
      quad = 2'd3;
      rem = 14'(t - 17'(3 * QUARTER_TURN));
    end else if (t >= 17'(2 * QUARTER_TURN)) begin
      quad = 2'd2;
      rem = 14'(t - 17'(2 * QUARTER_TURN));
    end else if (t >= 17'(QUARTER_TURN)) begin
      quad = 2'd1;
      rem = 14'(t - 17'(QUARTER_TURN));
    end else begin
      quad = 2'd0;
      rem = 14'(t);
    end
    x_full = 31'(r_r) * 31'(RAD_PER_UNIT_Q30);
    x_sq = 60'(x_r[1]) * 60'(x_r[1]);
    sin_sum = {1'b0, sn_r[11][29:0]} + 31'd32768;
    sin_b = sin_sum[30:16];
    cos_v4 = ONE_Q30 - 31'(cs_r[11][29:1]);
    cos_sum = 32'(cos_v4) + 32'd32768;
    cos_b = cos_sum[30:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Reduce to an octant argument and remember how to fold it back.
      ctl_r[0] <= '{swap: (rem > 14'(EIGHTH_TURN)), quad: quad};
      r_r <= (rem > 14'(EIGHTH_TURN)) ? 13'(14'(QUARTER_TURN) - rem) : rem[12:0];
      for (int k = 1; k < 12; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
      x_r[1] <= x_full[29:0];
      for (int k = 2; k < 11; k++) begin
        x_r[k] <= x_r[k-1];
      end
      x2_r[2] <= x_sq[59:30];
      for (int k = 3; k < 11; k++) begin
        x2_r[k] <= x2_r[k-1];
      end
      // Horner steps, sine on the left chain and cosine on the right.
      sn_r[3] <= 31'(recip_est(x2_r[2], RECIP_42));
      cs_r[3] <= 31'(recip_est(x2_r[2], RECIP_56));
      sn_r[4] <= ONE_Q30 - 31'(recip_fix(x2_r[3], sn_r[3][29:0], 6'd42));
      cs_r[4] <= ONE_Q30 - 31'(recip_fix(x2_r[3], cs_r[3][29:0], 6'd56));
      sn_r[5] <= 31'(mul_q30(x2_r[4], sn_r[4]));
      cs_r[5] <= 31'(mul_q30(x2_r[4], cs_r[4]));
      sn_r[6] <= 31'(recip_est(sn_r[5][29:0], RECIP_20));
      cs_r[6] <= 31'(recip_est(cs_r[5][29:0], RECIP_30));
      ns6_r <= sn_r[5][29:0];
      nc6_r <= cs_r[5][29:0];
      sn_r[7] <= ONE_Q30 - 31'(recip_fix(ns6_r, sn_r[6][29:0], 6'd20));
      cs_r[7] <= ONE_Q30 - 31'(recip_fix(nc6_r, cs_r[6][29:0], 6'd30));
      sn_r[8] <= 31'(mul_q30(x2_r[7], sn_r[7]));
      cs_r[8] <= 31'(mul_q30(x2_r[7], cs_r[7]));
      sn_r[9] <= 31'(recip_est(sn_r[8][29:0], RECIP_6));
      cs_r[9] <= 31'(recip_est(cs_r[8][29:0], RECIP_12));
      ns9_r <= sn_r[8][29:0];
      nc9_r <= cs_r[8][29:0];
      sn_r[10] <= ONE_Q30 - 31'(recip_fix(ns9_r, sn_r[9][29:0], 6'd6));
      cs_r[10] <= ONE_Q30 - 31'(recip_fix(nc9_r, cs_r[9][29:0], 6'd12));
      sn_r[11] <= 31'(mul_q30(x_r[10], sn_r[10]));
      cs_r[11] <= 31'(mul_q30(x2_r[10], cs_r[10]));
      // Octant swap and quadrant signs.
      case (ctl_r[11].quad)
        2'd0: begin
          sin_out <= ctl_r[11].swap ? $signed({1'b0, cos_b}) : $signed({1'b0, sin_b});
          cos_out <= ctl_r[11].swap ? $signed({1'b0, sin_b}) : $signed({1'b0, cos_b});
        end
        2'd1: begin
          sin_out <= ctl_r[11].swap ? $signed({1'b0, sin_b}) : $signed({1'b0, cos_b});
          cos_out <= ctl_r[11].swap ? -$signed({1'b0, cos_b}) : -$signed({1'b0, sin_b});
        end
        2'd2: begin
          sin_out <= ctl_r[11].swap ? -$signed({1'b0, cos_b}) : -$signed({1'b0, sin_b});
          cos_out <= ctl_r[11].swap ? -$signed({1'b0, sin_b}) : -$signed({1'b0, cos_b});
        end
        default: begin
          sin_out <= ctl_r[11].swap ? -$signed({1'b0, sin_b}) : -$signed({1'b0, cos_b});
          cos_out <= ctl_r[11].swap ? $signed({1'b0, cos_b}) : $signed({1'b0, sin_b});
        end
      endcase
    end
  end

endmodule

[rtl/core/dhfk_cell.sv]
// One joint of the chain: builds its DH transform and multiplies it onto
// the incoming transform. Depends on dhfk_pkg and dhfk_sincos.
module dhfk_cell import dhfk_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] link_len,
  input  logic signed [15:0] link_off,
  input  twist_t             twist,
  input  hstate_t            h_in,
  output hstate_t            h_out
);

  logic signed [15:0] s_q14, c_q14;

  hstate_t carry_r [0:12];
  hstate_t c13_r, c14_r, c15_r, out_r;
  logic signed [31:0] p_ct_r [3];
  logic signed [31:0] p_st_r [3];
  logic signed [31:0] p_0s_r [3];
  logic signed [31:0] p_1c_r [3];
  logic signed [31:0] act_r, ast_r;
  rot_t nrot14_r, nrot15_r, nrot;
  logic signed [17:0] ap0_r, ap1_r;
  logic signed [33:0] pp_r [3][3];
  pos_t npos;

  dhfk_sincos u_sincos (
    .clk     (clk),
    .en      (en),
    .ang     ($signed(h_in.ang[0])),
    .sin_out (s_q14),
    .cos_out (c_q14)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [39:0] col0, diff, r2s, col1, col2;
      col0 = 40'(p_ct_r[i]) + 40'(p_st_r[i]);
      diff = 40'(p_1c_r[i]) - 40'(p_0s_r[i]);
      r2s = 40'($signed(c13_r.rot[i][2])) <<< 14;
      case (twist)
        TWIST_0:   begin col1 = diff;  col2 = r2s;   end
        TWIST_90:  begin col1 = r2s;   col2 = -diff; end
        TWIST_180: begin col1 = -diff; col2 = -r2s;  end
        default:   begin col1 = -r2s;  col2 = diff;  end
      endcase
      nrot[i][0] = sat16(rnd14(col0));
      nrot[i][1] = sat16(rnd14(col1));
      nrot[i][2] = sat16(rnd14(col2));
    end
    for (int i = 0; i < 3; i++) begin
      logic signed [39:0] acc;
      acc = 40'(pp_r[i][0]) + 40'(pp_r[i][1]) + 40'(pp_r[i][2]);
      npos[i] = 32'($signed(c15_r.pos[i]) + 32'(rnd14(acc)));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry_r[0] <= h_in;
      for (int k = 1; k < 13; k++) begin
        carry_r[k] <= carry_r[k-1];
      end
      c13_r <= carry_r[12];
      for (int i = 0; i < 3; i++) begin
        p_ct_r[i] <= $signed(carry_r[12].rot[i][0]) * c_q14;
        p_st_r[i] <= $signed(carry_r[12].rot[i][1]) * s_q14;
        p_0s_r[i] <= $signed(carry_r[12].rot[i][0]) * s_q14;
        p_1c_r[i] <= $signed(carry_r[12].rot[i][1]) * c_q14;
      end
      act_r <= link_len * c_q14;
      ast_r <= link_len * s_q14;
      c14_r <= c13_r;
      nrot14_r <= nrot;
      ap0_r <= 18'(rnd14(40'(act_r)));
      ap1_r <= 18'(rnd14(40'(ast_r)));
      c15_r <= c14_r;
      nrot15_r <= nrot14_r;
      for (int i = 0; i < 3; i++) begin
        pp_r[i][0] <= $signed(c14_r.rot[i][0]) * ap0_r;
        pp_r[i][1] <= $signed(c14_r.rot[i][1]) * ap1_r;
        pp_r[i][2] <= 34'($signed(c14_r.rot[i][2])) * 34'(link_off);
      end
      out_r.rot <= nrot15_r;
      out_r.pos <= npos;
      out_r.ang <= {16'h0000, c15_r.ang[2], c15_r.ang[1]};
    end
  end

  assign h_out = out_r;

endmodule

[rtl/core/dhfk_checker.sv]
// Port-level checks of the kinematics core and the bind that attaches them.
// Depends on the macro header and the core's port list.
`include "dh_forward_kinematics_3joint_core_macros.svh"
module dhfk_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_rot_00,
  input logic signed [23:0] out_pos_x
);

  `DHFK_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result item dropped")
  `DHFK_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_rot_00) && $stable(out_pos_x), "stalled result changed")
  `DHFK_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result shown after reset")
  `DHFK_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input stalled with empty output")

endmodule

bind dh_forward_kinematics_3joint_core dhfk_port_checker u_dhfk_port_checker (.*);
